// File: sv/lehmer_random_with_bound_macros.svh
// assertion macros for the lehmer generator block
`ifndef LEHMER_RANDOM_WITH_BOUND_MACROS_SVH
`define LEHMER_RANDOM_WITH_BOUND_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LRWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lrwb_pkg.sv
`default_nettype none
package lrwb_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned MULT_W = 16;
  localparam int unsigned CNT_W  = 6;

  localparam logic [MULT_W-1:0] LCG_MULT = 16'd42871;
  localparam logic [WORD_W-1:0] LCG_MOD  = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] SEED_RST = 32'd1;

  localparam logic [1:0] OP_DRAW32     = 2'd0;
  localparam logic [1:0] OP_DRAW32_MOD = 2'd1;
  localparam logic [1:0] OP_DRAW64     = 2'd2;
  localparam logic [1:0] OP_DRAW64_MOD = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RED  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // 48-bit product folded mod 2^32-1: hi + lo, one conditional subtract
  function automatic logic [WORD_W-1:0] lcg_reduce(input logic [PROD_W-1:0] p);
    logic [WORD_W:0] s;
    s = {1'b0, p[WORD_W-1:0]} + {{(WORD_W+1-(PROD_W-WORD_W)){1'b0}}, p[PROD_W-1:WORD_W]};
    if (s >= {1'b0, LCG_MOD}) begin
      s = s - {1'b0, LCG_MOD};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/lehmer_random_with_bound.sv
// a 32-bit draw runs one multiply and fold; a 64-bit draw runs two, high word first
// bounded draws add a 64-step remainder loop, one bit per cycle, in a shared divider
// each draw is a multiply step and a fold step on the single 16x32 multiplier
// a new item is taken only in idle, after the last result is loaded; ST_OUT waits while the output is stalled
// synchronous active-low reset: generator state and seed return to 1, no item in flight
`default_nettype none
module lehmer_random_with_bound
  import lrwb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [WORD_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [WIDE_W-1:0] in_bound,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WIDE_W-1:0] out_value,
  output logic                   out_bad_bound,
  output logic      [WORD_W-1:0] out_state_after
);

  seq_state_t        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [WIDE_W-1:0] bound_r, bound_nxt;
  logic [WORD_W-1:0] gen_r, gen_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0] hi_r, hi_nxt;
  logic              second_r, second_nxt;
  logic [WIDE_W-1:0] res_r, res_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WIDE_W-1:0] out_value_r, out_value_nxt;
  logic              out_bad_r, out_bad_nxt;
  logic [WORD_W-1:0] out_state_r, out_state_nxt;

  logic [WORD_W-1:0] draw;
  logic [WIDE_W-1:0] raw;
  logic [WIDE_W-1:0] bnd;
  logic              wide_op;
  logic              mod_op;
  logic              div_start;
  div_sts_t          div_sts;
  logic [WIDE_W-1:0] div_rem;

  lrwb_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (raw),
    .divisor  (bnd),
    .sts      (div_sts),
    .rem      (div_rem)
  );

  always_comb begin
    wide_op = op_r inside {OP_DRAW64, OP_DRAW64_MOD};
    mod_op  = op_r inside {OP_DRAW32_MOD, OP_DRAW64_MOD};
    draw    = lcg_reduce(prod_r);
    raw     = wide_op ? {hi_r, draw} : {{(WIDE_W-WORD_W){1'b0}}, draw};
    bnd     = (op_r == OP_DRAW32_MOD) ? {{(WIDE_W-WORD_W){1'b0}}, bound_r[WORD_W-1:0]}
                                      : bound_r;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bound_nxt     = bound_r;
    gen_nxt       = gen_r;
    prod_nxt      = prod_r;
    hi_nxt        = hi_r;
    second_nxt    = second_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;
    out_state_nxt = out_state_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          bound_nxt  = in_bound;
          second_nxt = 1'b0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(LCG_MULT) * PROD_W'(gen_r);
        state_nxt = ST_RED;
      end
      ST_RED: begin
        gen_nxt = draw;
        if (wide_op && !second_r) begin
          hi_nxt     = draw;
          second_nxt = 1'b1;
          state_nxt  = ST_MUL;
        end else if (mod_op && (bnd == '0)) begin
          res_nxt   = '0;
          bad_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else if (mod_op) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          res_nxt   = raw;
          bad_nxt   = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          res_nxt   = div_rem;
          bad_nxt   = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_bad_nxt   = bad_r;
          out_state_nxt = gen_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      gen_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_r       <= SEED_RST;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    bound_r     <= bound_nxt;
    prod_r      <= prod_nxt;
    hi_r        <= hi_nxt;
    res_r       <= res_nxt;
    bad_r       <= bad_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
    out_state_r <= out_state_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_bad_bound   = out_bad_r;
  assign out_state_after = out_state_r;

endmodule
`default_nettype wire

// File: sv/lrwb_divider.sv
`default_nettype none
module lrwb_divider
  import lrwb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDE_W-1:0] dividend,
  input  wire logic [WIDE_W-1:0] divisor,
  output div_sts_t               sts,
  output logic      [WIDE_W-1:0] rem
);

  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [WIDE_W-1:0] dvd_r, dvd_nxt;
  logic [WIDE_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WIDE_W:0]   trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[WIDE_W-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = WIDE_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[WIDE_W-1:0];
      end
      dvd_nxt = {dvd_r[WIDE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

endmodule
`default_nettype wire

// File: sv/lehmer_random_with_bound_checker.sv
`default_nettype none
`include "lehmer_random_with_bound_macros.svh"
module lehmer_random_with_bound_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_value,
  input wire logic        out_bad_bound,
  input wire logic [31:0] out_state_after
);

  logic        in_acc;
  logic        out_wait;
  logic        bad_out;
  logic [97:0] out_bus;

  assign in_acc   = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;
  assign bad_out  = out_valid && out_bad_bound;
  assign out_bus  = {out_valid, out_value, out_bad_bound, out_state_after};

  `LRWB_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "accepted item left the block idle")
  `LRWB_ASSERT_NOW(a_bad_bound_zero, bad_out, out_value == '0, "nonzero value on bad bound")
  `LRWB_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without work")
  `LRWB_ASSERT_NEXT(a_out_hold, out_wait, $stable(out_bus), "stalled item changed")

endmodule

bind lehmer_random_with_bound lehmer_random_with_bound_checker u_chk (.*);
`default_nettype wire
